// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the cluster chain allocator.
// No dependencies; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Antecedent implies consequent in the same cycle.
`define FCCA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcca assertion failed");

// Antecedent implies consequent in the following cycle.
`define FCCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcca assertion failed");

// Plain invariant checked at every clock edge.
`define FCCA_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fcca assertion failed");

`else

`define FCCA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FCCA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define FCCA_ASSERT_ALWAYS(label, clk, rst_n, prop)

`endif

`endif

// ===== rtl/core/fcca_pkg.sv =====
// Package for the cluster chain allocator: sizes, codes and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package fcca_pkg;

    localparam int NUM_CLUSTERS      = 1024;
    localparam int RESERVED_CLUSTERS = 3;
    localparam int CL_W              = $clog2(NUM_CLUSTERS);
    localparam int ENT_W             = CL_W + 1;
    localparam int BYTES_W           = 32;
    localparam int LG_W              = 4;
    localparam int NEED_W            = BYTES_W + 1 - 9;
    localparam int STATUS_W          = 2;

    localparam logic [ENT_W-1:0] END_MARK   = {ENT_W{1'b1}};
    localparam logic [ENT_W-1:0] FREE_RESET = ENT_W'(NUM_CLUSTERS - RESERVED_CLUSTERS);
    localparam logic [ENT_W-1:0] TOTAL      = ENT_W'(NUM_CLUSTERS);
    localparam logic [LG_W-1:0]  LG_MIN     = LG_W'(9);
    localparam logic [LG_W-1:0]  LG_RESET   = LG_W'(12);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_ZERO     = 2'd2
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_load;
        logic calc;
        logic check;
        logic link;
        logic rd;
        logic look;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic op;
        logic zero;
        logic no_space;
        logic link_last;
    } dp_status_t;

endpackage

// ===== rtl/core/fcca_dp.sv =====
// Datapath of the cluster chain allocator: table memory, free count,
// size rounding, link writer and result registers. Depends on fcca_pkg.
`timescale 1ns / 1ps

module fcca_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fcca_pkg::LG_W-1:0]     cfg_wdata,
    input  logic                          in_op,
    input  logic [fcca_pkg::BYTES_W-1:0]  in_bytes,
    input  logic [fcca_pkg::CL_W-1:0]     in_cluster,
    input  fcca_pkg::ctrl_cmd_t           cmd,
    output fcca_pkg::dp_status_t          sts,
    output fcca_pkg::status_t             out_status,
    output logic [fcca_pkg::CL_W-1:0]     out_first,
    output logic [fcca_pkg::ENT_W-1:0]    out_used,
    output logic [fcca_pkg::ENT_W-1:0]    out_next,
    output logic                          out_end,
    output logic [fcca_pkg::ENT_W-1:0]    out_free
);
    import fcca_pkg::*;

    logic [LG_W-1:0]    cfg_lg_reg;
    logic [ENT_W-1:0]   free_count_reg;

    logic               op_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [CL_W-1:0]    cluster_reg;
    logic [LG_W-1:0]    lg_reg;
    logic [NEED_W-1:0]  need_reg;
    logic               zero_reg;
    logic [ENT_W-1:0]   base_reg;
    logic [ENT_W-1:0]   cnt_reg;

    logic [ENT_W-1:0]   mem [NUM_CLUSTERS];
    logic [ENT_W-1:0]   rd_data_reg;
    logic               rd_res_reg;
    logic               rd_free_reg;

    status_t            res_status_reg;
    logic [CL_W-1:0]    res_first_reg;
    logic [ENT_W-1:0]   res_used_reg;
    logic [ENT_W-1:0]   res_next_reg;
    logic               res_end_reg;

    status_t            out_status_reg;
    logic [CL_W-1:0]    out_first_reg;
    logic [ENT_W-1:0]   out_used_reg;
    logic [ENT_W-1:0]   out_next_reg;
    logic               out_end_reg;
    logic [ENT_W-1:0]   out_free_reg;

    logic [BYTES_W:0]   sum;
    logic [BYTES_W:0]   need_full;
    logic [ENT_W-1:0]   first_free;
    logic [ENT_W-1:0]   wr_addr;
    logic [ENT_W-1:0]   wr_data;
    logic               link_last;
    logic [ENT_W-1:0]   look_val;

    // Round the byte count up to whole clusters.
    assign sum       = {1'b0, bytes_reg} + ((BYTES_W+1)'(1) << lg_reg) - (BYTES_W+1)'(1);
    assign need_full = sum >> lg_reg;

    // Free clusters always form the top of the table, since allocation
    // takes the lowest free entries and nothing is released.
    assign first_free = TOTAL - free_count_reg;
    assign wr_addr    = base_reg + cnt_reg;
    assign link_last  = (cnt_reg + ENT_W'(1)) == need_reg[ENT_W-1:0];
    assign wr_data    = link_last ? END_MARK : wr_addr + ENT_W'(1);
    assign look_val   = rd_res_reg ? END_MARK : (rd_free_reg ? '0 : rd_data_reg);

    assign sts.op        = op_reg;
    assign sts.zero      = zero_reg;
    assign sts.no_space  = need_reg > NEED_W'(free_count_reg);
    assign sts.link_last = link_last;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_lg_reg     <= LG_RESET;
            free_count_reg <= FREE_RESET;
        end else begin
            if (cfg_we) begin
                cfg_lg_reg <= cfg_wdata;
            end
            if (cmd.link && link_last) begin
                free_count_reg <= free_count_reg - need_reg[ENT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.link) begin
            mem[wr_addr[CL_W-1:0]] <= wr_data;
        end
        if (cmd.rd) begin
            rd_data_reg <= mem[cluster_reg];
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.in_load) begin
            op_reg      <= in_op;
            bytes_reg   <= in_bytes;
            cluster_reg <= in_cluster;
            lg_reg      <= (cfg_lg_reg < LG_MIN) ? LG_MIN : cfg_lg_reg;
        end
        if (cmd.calc) begin
            need_reg <= need_full[NEED_W-1:0];
            zero_reg <= bytes_reg == '0;
        end
        if (cmd.check) begin
            base_reg      <= first_free;
            cnt_reg       <= '0;
            res_first_reg <= '0;
            res_used_reg  <= '0;
            res_next_reg  <= '0;
            res_end_reg   <= 1'b0;
            if (zero_reg) begin
                res_status_reg <= ST_ZERO;
            end else if (sts.no_space) begin
                res_status_reg <= ST_NO_SPACE;
            end else begin
                res_status_reg <= ST_OK;
            end
        end
        if (cmd.link) begin
            cnt_reg <= cnt_reg + ENT_W'(1);
            if (link_last) begin
                res_first_reg <= base_reg[CL_W-1:0];
                res_used_reg  <= need_reg[ENT_W-1:0];
            end
        end
        if (cmd.rd) begin
            rd_res_reg  <= ENT_W'(cluster_reg) < ENT_W'(RESERVED_CLUSTERS);
            rd_free_reg <= ENT_W'(cluster_reg) >= first_free;
        end
        if (cmd.look) begin
            res_status_reg <= ST_OK;
            res_first_reg  <= '0;
            res_used_reg   <= '0;
            res_next_reg   <= look_val;
            res_end_reg    <= look_val == END_MARK;
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_first_reg  <= res_first_reg;
            out_used_reg   <= res_used_reg;
            out_next_reg   <= res_next_reg;
            out_end_reg    <= res_end_reg;
            out_free_reg   <= free_count_reg;
        end
    end

    assign out_status = out_status_reg;
    assign out_first  = out_first_reg;
    assign out_used   = out_used_reg;
    assign out_next   = out_next_reg;
    assign out_end    = out_end_reg;
    assign out_free   = out_free_reg;

endmodule

// ===== rtl/core/fcca_ctrl.sv =====
// Controller of the cluster chain allocator: sequences one transaction
// through the datapath and owns the output valid. Depends on fcca_pkg.
`timescale 1ns / 1ps

module fcca_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  fcca_pkg::dp_status_t   sts,
    output fcca_pkg::ctrl_cmd_t    cmd
);
    import fcca_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_NEED  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_LINK  = 7'b0001000,
        S_READ  = 7'b0010000,
        S_LOOK  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   valid_reg;
    logic   valid_next;
    logic   out_free;

    assign out_free  = !valid_reg || out_ready;
    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.in_load = 1'b1;
                    state_next  = S_NEED;
                end
            end
            S_NEED: begin
                // The operation is known only after the input is captured.
                if (sts.op == OP_NEXT) begin
                    cmd.rd     = 1'b1;
                    state_next = S_LOOK;
                end else begin
                    cmd.calc   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                if (sts.zero || sts.no_space) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_LINK;
                end
            end
            S_LINK: begin
                cmd.link = 1'b1;
                if (sts.link_last) begin
                    state_next = S_DONE;
                end
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = S_LOOK;
            end
            S_LOOK: begin
                cmd.look   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== rtl/core/fat_cluster_chain_allocator.sv =====
// Top level of the cluster chain allocator: joins controller and datapath
// and packs the stream channels. Depends on fcca_pkg, fcca_ctrl, fcca_dp.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
// The slave channel takes one transaction per request. tuser carries the
// operation: allocate a chain of clusters for a byte count, or look up the
// table entry that follows a cluster. Every request yields exactly one
// transaction on the master channel with a status, the chain head and
// length for an allocation, the table entry and chain-end flag (tlast) for
// a lookup, and the free cluster count left afterwards.
// Requests are handled one at a time. A lookup reads the table entry, then
// resolves it and registers the result; an allocation computes the cluster
// count, checks the space, then runs the link writer that stores one table
// entry per cycle into the single write port of the table memory. Rejected
// allocations (zero size or not enough space) skip the link writer. The next
// request is taken in the cycle after a result is registered. A result waits
// in the output register while the receiver stalls; the block still accepts
// and processes the next request and only holds it before its own result is
// registered. Reset restores the empty table (three reserved clusters), the
// full free count and a 4 KiB cluster size at once: free entries are tracked
// by the free count, so no clearing pass is needed. The user must write log2 of the
// cluster size via cfg_we only while the block is idle; the block does not enforce it.
module fat_cluster_chain_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,    // cluster_size_log2
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,      // byte_count[31:0], cluster[41:32], zero pad
    input  logic        s_tuser,      // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,      // first_cluster[9:0], clusters_used[20:10],
                                      // next_cluster[31:21], free_left[42:32], zero pad
    output logic [1:0]  m_tuser,      // status
    output logic        m_tlast       // chain_end
);
    import fcca_pkg::*;

    ctrl_cmd_t         cmd;
    dp_status_t        sts;
    status_t           out_status;
    logic [CL_W-1:0]   out_first;
    logic [ENT_W-1:0]  out_used;
    logic [ENT_W-1:0]  out_next;
    logic              out_end;
    logic [ENT_W-1:0]  out_free;

    fcca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fcca_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_op      (s_tuser),
        .in_bytes   (s_tdata[31:0]),
        .in_cluster (s_tdata[41:32]),
        .cmd        (cmd),
        .sts        (sts),
        .out_status (out_status),
        .out_first  (out_first),
        .out_used   (out_used),
        .out_next   (out_next),
        .out_end    (out_end),
        .out_free   (out_free)
    );

    assign m_tdata = {5'd0, out_free, out_next, out_used, out_first};
    assign m_tuser = out_status;
    assign m_tlast = out_end;

    // Only one datapath action of the sequence is active in a cycle.
    `FCCA_ASSERT_ALWAYS(a_cmd_onehot, clk, rst_n, $onehot0(cmd))

    // Once a request is taken, no other is taken in the next cycle.
    `FCCA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // The free count never grows beyond its reset value.
    `FCCA_ASSERT_SAME(a_free_bound, clk, rst_n, m_tvalid, m_tdata[42:32] <= FREE_RESET)

    // A successful allocation never hands out a reserved cluster.
    `FCCA_ASSERT_SAME(a_no_reserved, clk, rst_n,
        m_tvalid && m_tuser == ST_OK && m_tdata[20:10] != 11'd0,
        m_tdata[9:0] >= 10'(RESERVED_CLUSTERS))

endmodule
